// ===== src/kpi_pkg.sv =====
`timescale 1ns / 1ps

package kpi_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_EXACT  = 3'd0,
        ST_FIRST  = 3'd1,
        ST_LAST   = 3'd2,
        ST_INTERP = 3'd3,
        ST_NOKEYS = 3'd4
    } t_status;

    // fixed field widths
    localparam int POS_W      = 32;
    localparam int IDX_FIELD_W = 5;
    localparam int TIME_FIELD_W = 16;
    localparam int CNT_REG_W  = 6;
    localparam int STATUS_W   = 3;

    // blend is Q0.16, produced two quotient bits per divider stage
    localparam int BLEND_W    = 16;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = BLEND_W / DIV_STEPS;

    // stream payload widths
    localparam int IN_FIELDS_W = IDX_FIELD_W + 2 * TIME_FIELD_W + 3 * POS_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 3 * POS_W;

endpackage

// ===== src/keyframe_position_interpolator.sv =====
`timescale 1ns / 1ps

// Keyframe position interpolator.
// Input stream s_axis: tuser[0] selects the kind of transfer (0 loads one key
// into the table at key_index, 1 samples the position at sample_time). Load
// transfers update the table and give no result; every sample transfer gives
// exactly one result transfer on m_axis: x, y, z in Q16.16 plus a status in
// tuser (exact key, held first, held last, interpolated, no keys).
// The key count register is written through i_cfg_we / i_cfg_data; write it
// only while the block is idle, which the block itself does not enforce. It
// takes effect for samples that follow. Throughput: one transfer per cycle
// while m_axis is not stalled. All key times sit in flops and are compared in
// parallel; the blend divide is a pipelined restoring divider with two
// quotient bits per stage, followed by one multiply stage and one add stage
// (14 register stages end to end).
// Reset clears the key count and all pipeline valid bits; the key table is
// not cleared and must be loaded before use.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
module keyframe_position_interpolator #(
    parameter int MAX_KEYS  = 32,
    parameter int TIME_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // key count register
    input  logic                                 i_cfg_we,
    input  logic [kpi_pkg::CNT_REG_W-1:0]        i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: key_index, key_time, key_x, key_y, key_z, sample_time, zero pad
    input  logic [kpi_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // tuser: func
    input  logic [0:0]                           s_axis_tuser,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: out_x, out_y, out_z
    output logic [kpi_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // tuser: status
    output logic [kpi_pkg::STATUS_W-1:0]         m_axis_tuser
);

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int TW    = TIME_BITS;
    localparam int RW    = TIME_BITS + 1;
    localparam int PW    = kpi_pkg::POS_W;
    localparam int DW    = kpi_pkg::POS_W + 1;
    localparam int BW    = kpi_pkg::BLEND_W;
    localparam int NST   = kpi_pkg::DIV_STAGES;
    localparam int MW    = DW + BW + 1;

    // pipeline advance: everything moves unless a result is stuck at the output
    logic w_adv;
    logic r_o_valid;
    assign w_adv         = !r_o_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // key count register
    logic [kpi_pkg::CNT_REG_W-1:0] r_key_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (i_cfg_we) begin
            r_key_count <= i_cfg_data;
        end
    end

    logic [CNT_W-1:0] w_n;
    assign w_n = (int'(r_key_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(r_key_count);

    // stage 1: captured input transfer
    logic                        r1_valid;
    logic                        r1_func;
    logic [kpi_pkg::IDX_FIELD_W-1:0] r1_idx;
    logic [TW-1:0]               r1_ktime;
    logic [PW-1:0]               r1_kx, r1_ky, r1_kz;
    logic [TW-1:0]               r1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_func  <= s_axis_tuser[0];
            r1_idx   <= s_axis_tdata[4:0];
            r1_ktime <= TW'(s_axis_tdata[20:5]);
            r1_kx    <= s_axis_tdata[52:21];
            r1_ky    <= s_axis_tdata[84:53];
            r1_kz    <= s_axis_tdata[116:85];
            r1_t     <= TW'(s_axis_tdata[132:117]);
        end
    end

    // key table: times in flops for the parallel compare, plus memories
    logic [TW-1:0] r_key_time [MAX_KEYS];
    logic [TW-1:0] m_time     [MAX_KEYS];
    logic [PW-1:0] m_x        [MAX_KEYS];
    logic [PW-1:0] m_y        [MAX_KEYS];
    logic [PW-1:0] m_z        [MAX_KEYS];

    logic             w_load;
    logic [IDX_W-1:0] w_waddr;
    assign w_load  = w_adv && r1_valid && !r1_func && (int'(r1_idx) < MAX_KEYS);
    assign w_waddr = IDX_W'(r1_idx);

    // key load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key_time[w_waddr] <= r1_ktime;
            m_time[w_waddr]     <= r1_ktime;
            m_x[w_waddr]        <= r1_kx;
            m_y[w_waddr]        <= r1_ky;
            m_z[w_waddr]        <= r1_kz;
        end
    end

    // parallel compare of the sample time against every valid key
    logic [MAX_KEYS-1:0] n_eq, n_gt;
    always_comb begin
        for (int i = 0; i < MAX_KEYS; i++) begin
            n_eq[i] = (i < int'(w_n)) && (r_key_time[i] == r1_t);
            n_gt[i] = (i < int'(w_n)) && (r_key_time[i] > r1_t);
        end
    end

    // stage 2: match vectors
    logic                r2_valid;
    logic [MAX_KEYS-1:0] r2_eq, r2_gt;
    logic [TW-1:0]       r2_t;
    logic [CNT_W-1:0]    r2_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid && r1_func;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_eq <= n_eq;
            r2_gt <= n_gt;
            r2_t  <= r1_t;
            r2_n  <= w_n;
        end
    end

    // first exact match and first later key
    logic [IDX_W-1:0] w_fe, w_fg;
    always_comb begin
        w_fe = '0;
        w_fg = '0;
        for (int i = MAX_KEYS - 1; i >= 0; i--) begin
            if (r2_eq[i]) begin
                w_fe = IDX_W'(i);
            end
            if (r2_gt[i]) begin
                w_fg = IDX_W'(i);
            end
        end
    end

    // choose bracketing entries and status
    logic [IDX_W-1:0]       n_lo, n_hi;
    kpi_pkg::t_status       n_status;
    logic [CNT_W-1:0]       w_last;
    assign w_last = r2_n - CNT_W'(1);

    always_comb begin
        n_hi = w_fg;
        n_lo = '0;
        if (r2_n == '0) begin
            n_status = kpi_pkg::ST_NOKEYS;
        end else if (|r2_eq) begin
            n_status = kpi_pkg::ST_EXACT;
            n_lo     = w_fe;
        end else if (!(|r2_gt)) begin
            n_status = kpi_pkg::ST_LAST;
            n_lo     = w_last[IDX_W-1:0];
        end else if (w_fg == '0) begin
            n_status = kpi_pkg::ST_FIRST;
        end else begin
            n_status = kpi_pkg::ST_INTERP;
            n_lo     = w_fg - IDX_W'(1);
        end
    end

    // stage 3: registered table reads
    logic             r3_valid;
    kpi_pkg::t_status r3_status;
    logic [TW-1:0]    r3_t, r3_tb, r3_tn;
    logic [PW-1:0]    r3_x0, r3_x1, r3_y0, r3_y1, r3_z0, r3_z1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_status <= n_status;
            r3_t      <= r2_t;
            r3_tb     <= m_time[n_lo];
            r3_tn     <= m_time[n_hi];
            r3_x0     <= m_x[n_lo];
            r3_x1     <= m_x[n_hi];
            r3_y0     <= m_y[n_lo];
            r3_y1     <= m_y[n_hi];
            r3_z0     <= m_z[n_lo];
            r3_z1     <= m_z[n_hi];
        end
    end

    // two restoring divide steps
    function automatic logic [RW+BW-1:0] f_div2(input logic [RW-1:0] rem,
                                                input logic [TW-1:0] den,
                                                input logic [BW-1:0] q);
        logic [RW-1:0] v_rem;
        logic [BW-1:0] v_q;
        v_rem = rem;
        v_q   = q;
        for (int s = 0; s < kpi_pkg::DIV_STEPS; s++) begin
            v_rem = {v_rem[RW-2:0], 1'b0};
            if (v_rem >= {1'b0, den}) begin
                v_rem = v_rem - {1'b0, den};
                v_q   = {v_q[BW-2:0], 1'b1};
            end else begin
                v_q   = {v_q[BW-2:0], 1'b0};
            end
        end
        return {v_rem, v_q};
    endfunction

    // divider stages: stage 0 holds the operands, each later stage adds two bits
    logic                    r_d_valid  [NST+1];
    kpi_pkg::t_status        r_d_status [NST+1];
    logic [RW-1:0]           r_d_rem    [NST+1];
    logic [TW-1:0]           r_d_den    [NST+1];
    logic [BW-1:0]           r_d_q      [NST+1];
    logic [PW-1:0]           r_d_x0     [NST+1];
    logic [PW-1:0]           r_d_y0     [NST+1];
    logic [PW-1:0]           r_d_z0     [NST+1];
    logic signed [DW-1:0]    r_d_dx     [NST+1];
    logic signed [DW-1:0]    r_d_dy     [NST+1];
    logic signed [DW-1:0]    r_d_dz     [NST+1];

    logic [RW+BW-1:0] n_div [NST];
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            n_div[k] = f_div2(r_d_rem[k], r_d_den[k], r_d_q[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_d_valid[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_d_valid[0] <= r3_valid;
            for (int k = 1; k <= NST; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // operands and position deltas
            r_d_status[0] <= r3_status;
            r_d_rem[0]    <= {1'b0, r3_t - r3_tb};
            r_d_den[0]    <= r3_tn - r3_tb;
            r_d_q[0]      <= '0;
            r_d_x0[0]     <= r3_x0;
            r_d_y0[0]     <= r3_y0;
            r_d_z0[0]     <= r3_z0;
            r_d_dx[0]     <= $signed({r3_x1[PW-1], r3_x1}) - $signed({r3_x0[PW-1], r3_x0});
            r_d_dy[0]     <= $signed({r3_y1[PW-1], r3_y1}) - $signed({r3_y0[PW-1], r3_y0});
            r_d_dz[0]     <= $signed({r3_z1[PW-1], r3_z1}) - $signed({r3_z0[PW-1], r3_z0});
            for (int k = 1; k <= NST; k++) begin
                r_d_status[k] <= r_d_status[k-1];
                r_d_rem[k]    <= n_div[k-1][RW+BW-1:BW];
                r_d_den[k]    <= r_d_den[k-1];
                r_d_q[k]      <= n_div[k-1][BW-1:0];
                r_d_x0[k]     <= r_d_x0[k-1];
                r_d_y0[k]     <= r_d_y0[k-1];
                r_d_z0[k]     <= r_d_z0[k-1];
                r_d_dx[k]     <= r_d_dx[k-1];
                r_d_dy[k]     <= r_d_dy[k-1];
                r_d_dz[k]     <= r_d_dz[k-1];
            end
        end
    end

    // multiply stage: delta times blend
    logic                 r_p_valid;
    kpi_pkg::t_status     r_p_status;
    logic [PW-1:0]        r_p_x0, r_p_y0, r_p_z0;
    logic signed [MW-1:0] r_p_mx, r_p_my, r_p_mz;
    logic signed [BW:0]   w_blend;
    assign w_blend = $signed({1'b0, r_d_q[NST]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_adv) begin
            r_p_valid <= r_d_valid[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_status <= r_d_status[NST];
            r_p_x0     <= r_d_x0[NST];
            r_p_y0     <= r_d_y0[NST];
            r_p_z0     <= r_d_z0[NST];
            r_p_mx     <= MW'(r_d_dx[NST] * w_blend);
            r_p_my     <= MW'(r_d_dy[NST] * w_blend);
            r_p_mz     <= MW'(r_d_dz[NST] * w_blend);
        end
    end

    // final add; the product shifted right is the floor of the scaled delta
    logic [PW-1:0] n_ox, n_oy, n_oz;
    always_comb begin
        case (r_p_status)
            kpi_pkg::ST_INTERP: begin
                n_ox = r_p_x0 + r_p_mx[BW+PW-1:BW];
                n_oy = r_p_y0 + r_p_my[BW+PW-1:BW];
                n_oz = r_p_z0 + r_p_mz[BW+PW-1:BW];
            end
            kpi_pkg::ST_NOKEYS: begin
                n_ox = '0;
                n_oy = '0;
                n_oz = '0;
            end
            default: begin
                n_ox = r_p_x0;
                n_oy = r_p_y0;
                n_oz = r_p_z0;
            end
        endcase
    end

    // output register
    logic [PW-1:0]    r_o_x, r_o_y, r_o_z;
    kpi_pkg::t_status r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_x      <= n_ox;
            r_o_y      <= n_oy;
            r_o_z      <= n_oz;
            r_o_status <= r_p_status;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_z, r_o_y, r_o_x};
    assign m_axis_tuser  = r_o_status;

endmodule

// ===== src/kpi_checker.sv =====
`timescale 1ns / 1ps

module kpi_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [kpi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [kpi_pkg::STATUS_W-1:0]      m_axis_tuser
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result transfer holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // input back-pressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // an empty table gives a zero position
    a_nokeys_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == kpi_pkg::ST_NOKEYS) |-> m_axis_tdata == '0)
        else $error("no-keys result not zero");

endmodule

bind keyframe_position_interpolator kpi_checker u_kpi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
